// ===== design/frustum_cull_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frustum cull test core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_CORE_ASSERT_SVH
`define FRUSTUM_CULL_TEST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Formats, configuration layout and compare helper for the frustum cull test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fct_pkg;

  localparam int COORD_W    = 20;
  localparam int AXIS_W     = 16;
  localparam int FACT_W     = 16;
  localparam int COORD_FRAC = 8;
  localparam int AXIS_FRAC  = 14;
  localparam int FACT_FRAC  = 12;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + AXIS_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int RAD_W  = COORD_W - 1;
  localparam int RADF_W = RAD_W + FACT_W;
  localparam int BY_W   = DOT_W + FACT_W + 1;
  localparam int BX_W   = BY_W + FACT_W + 1;
  localparam int CZ_W   = DOT_W + 2;
  localparam int CMP_W  = BX_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_A = (3 * COORD_W > 3 * AXIS_W) ? 3 * COORD_W : 3 * AXIS_W;
  localparam int CFG_DATA_W = (CFG_DATA_A > 2 * FACT_W) ? CFG_DATA_A : 2 * FACT_W;

  localparam int PIPE_DEPTH = 6;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic        [FACT_W-1:0]  fact_t;
  typedef axis_t       [2:0]         vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA      = 3'd0,
    CFG_AXIS_X      = 3'd1,
    CFG_AXIS_Y      = 3'd2,
    CFG_AXIS_Z      = 3'd3,
    CFG_NEAR_FAR    = 3'd4,
    CFG_TAN_RATIO   = 3'd5,
    CFG_SPHERE_FACT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    V_OUTSIDE   = 2'd0,
    V_INSIDE    = 2'd1,
    V_INTERSECT = 2'd2
  } verdict_e;

  typedef struct packed {
    coord_t [2:0] cam;
    vec_t   [2:0] axis;
    coord_t       near_d;
    coord_t       far_d;
    fact_t        tn;
    fact_t        ra;
    fact_t        fy;
    fact_t        fx;
  } cfg_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] az;
    logic signed [DOT_W-1:0] ay;
    logic signed [DOT_W-1:0] ax;
    logic [RAD_W-1:0]        rad;
    logic [RADF_W-1:0]       radf_y;
    logic [RADF_W-1:0]       radf_x;
  } proj_t;

  localparam axis_t  AX_ONE   = axis_t'(1 << AXIS_FRAC);
  localparam axis_t  AX_ZERO  = axis_t'(0);
  localparam fact_t  FACT_ONE = fact_t'(1 << FACT_FRAC);

  localparam cfg_t CFG_RESET = '{
    cam:    '0,
    axis:   {{AX_ONE, AX_ZERO, AX_ZERO},
             {AX_ZERO, AX_ONE, AX_ZERO},
             {AX_ZERO, AX_ZERO, AX_ONE}},
    near_d: coord_t'(1 << COORD_FRAC),
    far_d:  coord_t'(1000 << COORD_FRAC),
    tn:     FACT_ONE,
    ra:     FACT_ONE,
    fy:     FACT_ONE,
    fx:     FACT_ONE
  };

  // Classify v against +/- bnd widened and narrowed by d
  function automatic verdict_e side_test(input logic signed [CMP_W-1:0] v,
                                         input logic signed [CMP_W-1:0] bnd,
                                         input logic signed [CMP_W-1:0] d,
                                         input verdict_e res);
    logic signed [CMP_W-1:0] hi_out;
    logic signed [CMP_W-1:0] lo_out;
    logic signed [CMP_W-1:0] hi_in;
    logic signed [CMP_W-1:0] lo_in;
    verdict_e r;
    hi_out = bnd + d;
    lo_out = -bnd - d;
    hi_in  = bnd - d;
    lo_in  = -bnd + d;
    if (res == V_OUTSIDE) begin
      r = V_OUTSIDE;
    end else if ((hi_out < v) || (v < lo_out)) begin
      r = V_OUTSIDE;
    end else if ((hi_in < v) || (v < lo_in)) begin
      r = V_INTERSECT;
    end else begin
      r = res;
    end
    return r;
  endfunction

endpackage

// ===== design/fct_cfg.sv =====
// ----------------------------------------------------------------------------
// fct_cfg
// Configuration register file; decodes each write into its fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output fct_pkg::cfg_t                 cfg_o
);
  import fct_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    case (cfg_index_i)
      CFG_CAMERA: begin
        for (int i = 0; i < 3; i++) begin
          cfg_d.cam[i] = cfg_data_i[i*COORD_W +: COORD_W];
        end
      end
      CFG_AXIS_X: begin
        for (int i = 0; i < 3; i++) begin
          cfg_d.axis[0][i] = cfg_data_i[i*AXIS_W +: AXIS_W];
        end
      end
      CFG_AXIS_Y: begin
        for (int i = 0; i < 3; i++) begin
          cfg_d.axis[1][i] = cfg_data_i[i*AXIS_W +: AXIS_W];
        end
      end
      CFG_AXIS_Z: begin
        for (int i = 0; i < 3; i++) begin
          cfg_d.axis[2][i] = cfg_data_i[i*AXIS_W +: AXIS_W];
        end
      end
      CFG_NEAR_FAR: begin
        cfg_d.near_d = cfg_data_i[COORD_W-1:0];
        cfg_d.far_d  = cfg_data_i[2*COORD_W-1:COORD_W];
      end
      CFG_TAN_RATIO: begin
        cfg_d.tn = cfg_data_i[FACT_W-1:0];
        cfg_d.ra = cfg_data_i[2*FACT_W-1:FACT_W];
      end
      CFG_SPHERE_FACT: begin
        cfg_d.fy = cfg_data_i[FACT_W-1:0];
        cfg_d.fx = cfg_data_i[2*FACT_W-1:FACT_W];
      end
      default: begin
        cfg_d = cfg_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/fct_proj.sv =====
// ----------------------------------------------------------------------------
// fct_proj
// Three stages: camera offset, axis products, dot product sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_proj (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fct_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic signed [fct_pkg::COORD_W-1:0] px_i,
  input  logic signed [fct_pkg::COORD_W-1:0] py_i,
  input  logic signed [fct_pkg::COORD_W-1:0] pz_i,
  input  logic [fct_pkg::RAD_W-1:0]         radius_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fct_pkg::proj_t                    out_o
);
  import fct_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] en;

  logic signed [COORD_W-1:0] p [3];
  logic signed [DIFF_W-1:0]  d_q [3];
  logic [RAD_W-1:0]          rad1_q;
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic [RAD_W-1:0]          rad2_q;
  logic [RADF_W-1:0]         radf_y2_q;
  logic [RADF_W-1:0]         radf_x2_q;
  proj_t                     out_q;
  proj_t                     out_d;

  assign en[2] = !valid_q[2] || !out_stall_i;
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];

  assign p[0] = px_i;
  assign p[1] = py_i;
  assign p[2] = pz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // offset from camera
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= DIFF_W'(p[i]) - DIFF_W'($signed(cfg_i.cam[i]));
      end
      rad1_q <= cmd_i ? radius_i : '0;
    end
  end

  // axis products
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[k][i] <= PROD_W'(d_q[i]) * PROD_W'($signed(cfg_i.axis[k][i]));
        end
      end
      rad2_q    <= rad1_q;
      radf_y2_q <= RADF_W'(rad1_q) * RADF_W'(cfg_i.fy);
      radf_x2_q <= RADF_W'(rad1_q) * RADF_W'(cfg_i.fx);
    end
  end

  // dot product sums
  always_comb begin
    out_d.ax     = DOT_W'(prod_q[0][0]) + DOT_W'(prod_q[0][1]) + DOT_W'(prod_q[0][2]);
    out_d.ay     = DOT_W'(prod_q[1][0]) + DOT_W'(prod_q[1][1]) + DOT_W'(prod_q[1][2]);
    out_d.az     = DOT_W'(prod_q[2][0]) + DOT_W'(prod_q[2][1]) + DOT_W'(prod_q[2][2]);
    out_d.rad    = rad2_q;
    out_d.radf_y = radf_y2_q;
    out_d.radf_x = radf_x2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[2];
  assign out_o       = out_q;

endmodule

// ===== design/fct_bound.sv =====
// ----------------------------------------------------------------------------
// fct_bound
// Three stages: depth test and y bound, x bound and y test, x test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_bound (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fct_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fct_pkg::proj_t    in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fct_pkg::verdict_e verdict_o
);
  import fct_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] en;

  logic signed [CZ_W-1:0]  z;
  logic signed [CZ_W-1:0]  r;
  logic signed [CZ_W-1:0]  nearv;
  logic signed [CZ_W-1:0]  farv;
  verdict_e                res4_d;

  verdict_e                res4_q;
  logic signed [BY_W-1:0]  bnd_y4_q;
  logic signed [DOT_W-1:0] ay4_q;
  logic signed [DOT_W-1:0] ax4_q;
  logic [RADF_W-1:0]       radf_y4_q;
  logic [RADF_W-1:0]       radf_x4_q;

  verdict_e                res5_q;
  logic signed [BX_W-1:0]  bnd_x5_q;
  logic signed [DOT_W-1:0] ax5_q;
  logic [RADF_W-1:0]       radf_x5_q;

  verdict_e                res6_q;

  assign en[2] = !valid_q[2] || !out_stall_i;
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // depth window at binary point 22
  always_comb begin
    z     = CZ_W'(in_i.az);
    r     = CZ_W'($signed({1'b0, in_i.rad})) <<< AXIS_FRAC;
    nearv = CZ_W'($signed(cfg_i.near_d)) <<< AXIS_FRAC;
    farv  = CZ_W'($signed(cfg_i.far_d)) <<< AXIS_FRAC;
    if ((farv + r < z) || (z < nearv - r)) begin
      res4_d = V_OUTSIDE;
    end else if ((farv - r < z) || (z < nearv + r)) begin
      res4_d = V_INTERSECT;
    end else begin
      res4_d = V_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      res4_q    <= res4_d;
      bnd_y4_q  <= BY_W'(in_i.az) * BY_W'($signed({1'b0, cfg_i.tn}));
      ay4_q     <= in_i.ay;
      ax4_q     <= in_i.ax;
      radf_y4_q <= in_i.radf_y;
      radf_x4_q <= in_i.radf_x;
    end
  end

  // y test at binary point 34, x bound
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      res5_q    <= side_test(CMP_W'(ay4_q) <<< FACT_FRAC,
                             CMP_W'(bnd_y4_q),
                             CMP_W'($signed({1'b0, radf_y4_q})) <<< AXIS_FRAC,
                             res4_q);
      bnd_x5_q  <= BX_W'(bnd_y4_q) * BX_W'($signed({1'b0, cfg_i.ra}));
      ax5_q     <= ax4_q;
      radf_x5_q <= radf_x4_q;
    end
  end

  // x test at binary point 46
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      res6_q <= side_test(CMP_W'(ax5_q) <<< (2 * FACT_FRAC),
                          CMP_W'(bnd_x5_q),
                          CMP_W'($signed({1'b0, radf_x5_q})) <<< (AXIS_FRAC + FACT_FRAC),
                          res5_q);
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[2];
  assign verdict_o   = res6_q;

endmodule

// ===== design/frustum_cull_test_core.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// Each test passes through six pipeline stages, each with a valid bit;
// throughput is one test per cycle while the output is not stalled.
// The x bound multiply (y bound times aspect ratio) sets the stage depth.
// Reset clears all valid bits and loads the default camera and frustum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_cull_test_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fct_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic signed [fct_pkg::COORD_W-1:0] px_i,
  input  logic signed [fct_pkg::COORD_W-1:0] py_i,
  input  logic signed [fct_pkg::COORD_W-1:0] pz_i,
  input  logic [fct_pkg::RAD_W-1:0]         radius_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        verdict_o
);
  import fct_pkg::*;

  cfg_t     cfg;
  proj_t    proj;
  logic     proj_valid;
  logic     proj_stall;
  verdict_e verdict;

  fct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fct_proj u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .radius_i    (radius_i),
    .out_valid_o (proj_valid),
    .out_stall_i (proj_stall),
    .out_o       (proj)
  );

  fct_bound u_bound (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (proj_valid),
    .in_stall_o  (proj_stall),
    .in_i        (proj),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict)
  );

  assign verdict_o = verdict;

endmodule

// ===== design/fct_checker.sv =====
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks on transfers in flight through the cull test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frustum_cull_test_core_assert.svh"

module fct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);
  import fct_pkg::*;

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    case ({in_xfer, out_xfer})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `FCT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(verdict_o), "stalled result changed")
  `FCT_ASSERT_NOW(a_no_orphan, out_valid_o, cnt_q != '0, "result without a pending input transfer")
  `FCT_ASSERT_NOW(a_depth, in_xfer && !out_xfer, cnt_q < CNT_W'(PIPE_DEPTH), "more transfers in flight than stages")
  `FCT_ASSERT_NOW(a_empty_ready, cnt_q == '0, !in_stall_o, "empty pipeline stalls input")

endmodule

bind frustum_cull_test_core fct_checker u_fct_checker (.*);

// ===== dv/tb_frustum_cull_test_core.sv =====
// ----------------------------------------------------------------------------
// Frustum cull test core testbench
// Streams point and sphere probes through the core under several camera and
// frustum settings: the defaults, random orthonormal cameras, inverted depth
// range and all-zero, all-one, random and signed-extreme register values.
// An exact 128-bit predictor forms the expected verdict at each input
// transfer, and the monitor compares each output transfer in order. Sender
// and receiver idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frustum_cull_test_core;
  import fct_pkg::*;

  localparam int NUM_SETUPS  = 9;
  localparam int PER_SETUP   = 180;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic             sphere;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic [RAD_W-1:0] rad;
  } probe_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i       = 1'b0;
  coord_t                px_i        = '0;
  coord_t                py_i        = '0;
  coord_t                pz_i        = '0;
  logic [RAD_W-1:0]      radius_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            verdict_o;

  logic [59:0] cam_pos      = '0;
  logic [47:0] right_axis   = 48'h0000_0000_4000;
  logic [47:0] up_axis      = 48'h0000_4000_0000;
  logic [47:0] view_axis    = 48'h4000_0000_0000;
  logic [39:0] depth_range  = 40'h3E800_00100;
  logic [31:0] tan_aspect   = 32'h1000_1000;
  logic [31:0] sphere_scale = 32'h1000_1000;

  probe_t   probe_q[$];
  verdict_e verdict_q[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_armed    = 1'b0;
  int  hold_count    = 0;
  bit  sent          = 1'b0;
  int  quiet_cycles  = 0;
  int  errors        = 0;
  int  checked       = 0;
  int  verdict_seen[3];

  frustum_cull_test_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .radius_i    (radius_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [127:0] onto_axis(logic signed [127:0] d0, d1, d2,
                                                    input logic [47:0] axis);
    logic signed [127:0] c0, c1, c2;
    c0 = 128'($signed(axis[AXIS_W-1:0]));
    c1 = 128'($signed(axis[2*AXIS_W-1:AXIS_W]));
    c2 = 128'($signed(axis[3*AXIS_W-1:2*AXIS_W]));
    return d0 * c0 + d1 * c1 + d2 * c2;
  endfunction

  function automatic verdict_e side_check(logic signed [127:0] v, lim, slack,
                                          input verdict_e prior);
    if ((lim + slack < v) || (v < -lim - slack)) return V_OUTSIDE;
    if ((lim - slack < v) || (v < -lim + slack)) return V_INTERSECT;
    return prior;
  endfunction

  function automatic verdict_e cull_verdict(logic sphere, coord_t x, coord_t y, coord_t z,
                                            logic [RAD_W-1:0] radius);
    logic signed [127:0] d0, d1, d2, az, ay, ax, rad, rz, lim_n, lim_f, tn, ra, fy, fx;
    verdict_e res;
    d0 = 128'(x) - 128'($signed(cam_pos[COORD_W-1:0]));
    d1 = 128'(y) - 128'($signed(cam_pos[2*COORD_W-1:COORD_W]));
    d2 = 128'(z) - 128'($signed(cam_pos[3*COORD_W-1:2*COORD_W]));
    az = onto_axis(d0, d1, d2, view_axis);
    ay = onto_axis(d0, d1, d2, up_axis);
    ax = onto_axis(d0, d1, d2, right_axis);
    rad = '0;
    if (sphere) rad = 128'(radius);
    tn = 128'(tan_aspect[15:0]);
    ra = 128'(tan_aspect[31:16]);
    fy = 128'(sphere_scale[15:0]);
    fx = 128'(sphere_scale[31:16]);
    rz = rad <<< AXIS_FRAC;
    lim_n = 128'($signed(depth_range[COORD_W-1:0]));
    lim_n = lim_n <<< AXIS_FRAC;
    lim_f = 128'($signed(depth_range[2*COORD_W-1:COORD_W]));
    lim_f = lim_f <<< AXIS_FRAC;
    if ((lim_f + rz < az) || (az < lim_n - rz)) begin
      res = V_OUTSIDE;
    end else begin
      res = ((lim_f - rz < az) || (az < lim_n + rz)) ? V_INTERSECT : V_INSIDE;
      res = side_check(ay <<< FACT_FRAC, az * tn, (rad * fy) <<< AXIS_FRAC, res);
      if (res != V_OUTSIDE) begin
        res = side_check(ax <<< (2 * FACT_FRAC), az * (tn * ra),
                         (rad * fx) <<< (AXIS_FRAC + FACT_FRAC), res);
      end
    end
    return res;
  endfunction

  function automatic longint rnd_between(longint lo, longint hi);
    longint unsigned span, r;
    if (hi <= lo) return lo;
    span = $unsigned(hi - lo) + 1;
    r = {$urandom, $urandom};
    return lo + longint'(r % span);
  endfunction

  function automatic longint axis_comp(logic [47:0] axis, int c);
    return longint'($signed(axis[AXIS_W*c +: AXIS_W]));
  endfunction

  function automatic longint edge_offset(longint lim, longint rad);
    case ($urandom_range(7))
      0:       return lim;
      1:       return -lim;
      default: return rnd_between(-(lim + lim / 4 + rad + 1), lim + lim / 4 + rad + 1);
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return RAD_W'($urandom_range(0, (1 << RAD_W) - 1));
      default: return RAD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic probe_t noise_probe();
    probe_t p;
    p.sphere = 1'($urandom_range(1));
    p.x      = coord_t'($urandom);
    p.y      = coord_t'($urandom);
    p.z      = coord_t'($urandom);
    p.rad    = RAD_W'($urandom_range(0, (1 << RAD_W) - 1));
    return p;
  endfunction

  // Aim at the frustum in camera space, then map back through the axes
  function automatic probe_t aimed_probe();
    probe_t p;
    coord_t pt[3];
    longint lo, hi, mg, t, ly, lx, u, s, off, tmp;
    int c;
    p.sphere = 1'($urandom_range(1));
    p.rad    = pick_radius();
    lo = longint'($signed(depth_range[COORD_W-1:0]));
    hi = longint'($signed(depth_range[2*COORD_W-1:COORD_W]));
    if (hi < lo) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    mg = (hi - lo) / 8 + 256 + longint'(p.rad);
    case ($urandom_range(7))
      0:       t = lo;
      1:       t = hi;
      default: t = rnd_between(lo - mg, hi + mg);
    endcase
    ly = (((t < 0) ? -t : t) * longint'(tan_aspect[15:0])) >>> FACT_FRAC;
    lx = (ly * longint'(tan_aspect[31:16])) >>> FACT_FRAC;
    u  = edge_offset(ly, longint'(p.rad));
    s  = edge_offset(lx, longint'(p.rad));
    for (c = 0; c < 3; c++) begin
      off = s * axis_comp(right_axis, c) + u * axis_comp(up_axis, c)
          + t * axis_comp(view_axis, c);
      tmp = longint'($signed(cam_pos[COORD_W*c +: COORD_W])) + (off >>> AXIS_FRAC);
      pt[c] = coord_t'(tmp);
    end
    p.x = pt[0];
    p.y = pt[1];
    p.z = pt[2];
    return p;
  endfunction

  task automatic queue_probe(int sphere, int x, int y, int z, int r);
    probe_t p;
    p.sphere = 1'(sphere);
    p.x      = coord_t'(x);
    p.y      = coord_t'(y);
    p.z      = coord_t'(z);
    p.rad    = RAD_W'(r);
    probe_q.push_back(p);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [59:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      CFG_CAMERA:      cam_pos      = value;
      CFG_AXIS_X:      right_axis   = value[47:0];
      CFG_AXIS_Y:      up_axis      = value[47:0];
      CFG_AXIS_Z:      view_axis    = value[47:0];
      CFG_NEAR_FAR:    depth_range  = value[39:0];
      CFG_TAN_RATIO:   tan_aspect   = value[31:0];
      CFG_SPHERE_FACT: sphere_scale = value[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_frustum(logic [59:0] cam, axx, axy, axz, nf, tr, sf);
    write_reg(CFG_CAMERA, cam);
    write_reg(CFG_AXIS_X, axx);
    write_reg(CFG_AXIS_Y, axy);
    write_reg(CFG_AXIS_Z, axz);
    write_reg(CFG_NEAR_FAR, nf);
    write_reg(CFG_TAN_RATIO, tr);
    write_reg(CFG_SPHERE_FACT, sf);
  endtask

  // Orthonormal axes: a signed permutation of the unit vectors
  task automatic load_camera(bit invert_depth);
    int order[3];
    int i, j, tmp, nearv, farv;
    logic [47:0] ax[3];
    logic [59:0] cam;
    order = '{0, 1, 2};
    for (i = 2; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < 3; i++) begin
      ax[i] = '0;
      ax[i][AXIS_W*order[i] +: AXIS_W] = $urandom_range(1) ? 16'h4000 : 16'hC000;
      cam[COORD_W*i +: COORD_W] = COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
    end
    nearv = $urandom_range(0, 2560);
    farv  = nearv + $urandom_range(256, 1 << 18);
    if (invert_depth) begin
      tmp   = nearv;
      nearv = farv;
      farv  = tmp;
    end
    program_frustum(cam, 60'(ax[0]), 60'(ax[1]), 60'(ax[2]), 60'({20'(farv), 20'(nearv)}),
                    60'({16'($urandom_range(16'h0800, 16'h2000)),
                         16'($urandom_range(16'h0200, 16'h2000))}),
                    60'({16'($urandom_range(16'h0400, 16'h3000)),
                         16'($urandom_range(16'h0400, 16'h3000))}));
  endtask

  // Check after the falling-edge updates have settled
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (probe_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      verdict_q.push_back(cull_verdict(cmd_i, px_i, py_i, pz_i, radius_i));
      sent = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_probes
    probe_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || sent) begin
      sent = 1'b0;
      if (probe_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = probe_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= nxt.sphere;
        px_i       <= nxt.x;
        py_i       <= nxt.y;
        pz_i       <= nxt.z;
        radius_i   <= nxt.rad;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_armed && hold_count < LONG_HOLD) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_verdicts
    verdict_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked++;
      if (verdict_o < 2'd3) verdict_seen[verdict_o]++;
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict %0d transferred with nothing expected", $time, verdict_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_o !== want) begin
          $display("%0t: verdict mismatch: expected %0d (%s), actual %0d",
                   $time, want, want.name(), verdict_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
               $time, quiet_cycles, verdict_q.size());
      $display("tb_frustum_cull_test_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k, n;
    verdict_seen = '{0, 0, 0};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (k = 0; k < NUM_SETUPS; k++) begin
      send_idle_pct = (k < 3) ? 13 : (k < 6) ? 62 : 0;
      recv_idle_pct = (k < 3) ? 62 : (k < 6) ? 13 : 0;
      case (k)
        0: begin
          queue_probe(0, 0, 0, 256, 0);
          queue_probe(0, 0, 0, 255, 0);
          queue_probe(0, 0, 0, 256000, 0);
          queue_probe(0, 0, 0, 256001, 0);
          queue_probe(0, 0, 512, 512, 0);
          queue_probe(0, 0, 513, 512, 0);
          queue_probe(0, -512, 0, 512, 0);
          queue_probe(0, -513, 0, 512, 0);
          queue_probe(0, 0, 0, 0, 0);
          queue_probe(0, -524288, -524288, -524288, 524287);
          queue_probe(0, 524287, 524287, 524287, 524287);
          queue_probe(0, 100, -200, 25600, 524287);
          queue_probe(1, 0, 0, 256, 0);
          queue_probe(1, 0, 512, 512, 0);
          queue_probe(1, 768, 0, 512, 256);
          queue_probe(1, 0, 0, -256, 1024);
          queue_probe(1, 0, 0, 25600, 256);
          queue_probe(1, 0, 0, -25600, 256);
          queue_probe(1, 0, 0, 256000, 512);
          queue_probe(1, 0, 0, 0, 524287);
          queue_probe(1, -524288, 524287, -524288, 524287);
          queue_probe(1, 524287, -524288, 524287, 0);
          queue_probe(1, 0, 1000, 512, 300);
        end
        2: program_frustum('1, '1, '1, '1, '1, '1, '1);
        3: load_camera(1'b1);
        5: program_frustum('0, '0, '0, '0, '0, '0, '0);
        7: program_frustum(60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                           60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                           60'({$urandom, $urandom}), 60'($urandom), 60'($urandom));
        8: program_frustum({20'h80000, 20'h7FFFF, 20'h80000},
                           60'({16'h7FFF, 16'h8000, 16'h7FFF}),
                           60'({16'h8000, 16'h7FFF, 16'h8000}),
                           60'({16'h7FFF, 16'h7FFF, 16'h8000}),
                           60'({20'h7FFFF, 20'h80000}), 60'(32'hFFFF_FFFF),
                           60'(32'hFFFF_FFFF));
        default: load_camera(1'b0);
      endcase
      for (n = 0; n < PER_SETUP; n++) begin
        probe_q.push_back(($urandom_range(3) == 0) ? noise_probe() : aimed_probe());
      end
      if (k == 6) hold_armed = 1'b1;
      wait_drained();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d point and sphere tests checked over %0d frustum settings", checked, NUM_SETUPS);
    $display("verdicts seen: %0d outside, %0d inside, %0d intersecting",
             verdict_seen[0], verdict_seen[1], verdict_seen[2]);
    if (errors == 0) begin
      $display("tb_frustum_cull_test_core OK");
    end else begin
      $display("tb_frustum_cull_test_core NOT OK");
    end
    $finish;
  end

endmodule
